// ===== design/pps_pkg.sv =====
`default_nettype none

package pps_pkg;

	localparam int START_W = 32;
	localparam int COUNT_W = 7;
	localparam int PRIME_W = 32;

	localparam int SMALLEST_PRIME = 2;
	localparam int SECOND_PRIME   = 3;
	localparam int FIRST_DIV      = 5;
	localparam int DIV_STEP       = 6;
	localparam int PAIR_OFFSET    = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAND,
		ST_MOD3,
		ST_CHK,
		ST_MODA,
		ST_MODB,
		ST_EMIT
	} pps_state_t;

	typedef struct packed {
		logic done;
		logic zero;
	} mod_stat_t;

endpackage

`default_nettype wire

// ===== design/pps_req_if.sv =====
`default_nettype none

interface pps_req_if
	import pps_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [START_W-1:0] start_value;
	logic [COUNT_W-1:0] prime_count;

	modport source(output valid, output start_value, output prime_count, input ready);
	modport sink(input valid, input start_value, input prime_count, output ready);
endinterface

`default_nettype wire

// ===== design/pps_res_if.sv =====
`default_nettype none

interface pps_res_if
	import pps_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [PRIME_W-1:0] prime_value;
	logic               found;
	logic               last;

	modport source(output valid, output prime_value, output found, output last, input ready);
	modport sink(input valid, input prime_value, input found, input last, output ready);
endinterface

`default_nettype wire

// ===== design/pps_mod_unit.sv =====
`default_nettype none

module pps_mod_unit
	import pps_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int DIV_BITS   = 18
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] dividend,
	input  wire logic [DIV_BITS-1:0]   divisor,
	output mod_stat_t                  stat
);

	localparam int CNT_W = $clog2(VALUE_BITS);

	logic                  busy_q;
	logic                  done_q;
	logic                  zero_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] num_q;
	logic [DIV_BITS-1:0]   div_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [DIV_BITS:0]     trial;
	logic [DIV_BITS:0]     rem_next;
	logic                  last_step;

	always_comb begin
		trial     = {rem_q, num_q[VALUE_BITS-1]};
		rem_next  = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
		last_step = (cnt_q == CNT_W'(VALUE_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last_step) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[VALUE_BITS-2:0], 1'b0};
			rem_q <= rem_next[DIV_BITS-1:0];
			cnt_q <= cnt_q + CNT_W'(1);
			if (last_step) begin
				zero_q <= (rem_next == '0);
			end
		end
	end

	assign stat.done = done_q;
	assign stat.zero = zero_q;

endmodule

`default_nettype wire

// ===== design/previous_prime_search.sv =====
// Descending prime search.
// req channel: start_value and prime_count. res channel: one result per prime,
// prime_value / found / last, valid-ready on both sides.
// A request yields the largest prime below start_value, then the largest
// prime below that one, until prime_count primes (saturated to MAX_COUNT)
// are delivered; the final one carries last. A count of zero gives no result.
// If no prime is left above 1 the request closes with one result carrying
// found = 0, prime_value = 0 and last = 1.
// Each candidate is tested by trial division in one shared restoring modulo
// unit, one quotient bit a cycle; odd candidates take one division by 3 and
// then two divisions for each 6k +/- 1 pair up to the square root.
// req is accepted only while idle; the next request can be taken while the
// final result still sits in the output register.
// When res stalls, the finished result is held and the search waits.
// Reset clears the sequencer and the output valid; no memory needs clearing.
`default_nettype none

module previous_prime_search
	import pps_pkg::*;
#(
	parameter int MAX_COUNT  = 64,
	parameter int VALUE_BITS = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	pps_req_if.sink   req,
	pps_res_if.source res
);

	localparam int DIV_BITS = VALUE_BITS / 2 + 2;
	localparam int SQ_BITS  = 2 * DIV_BITS;
	localparam int CNT_W    = $clog2(MAX_COUNT + 1);

	pps_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] cand_q;
	logic [DIV_BITS-1:0]   d_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic [CNT_W-1:0]      remaining_q;
	logic                  pend_found_q;
	logic                  pend_last_q;
	logic                  res_valid_q;
	logic [PRIME_W-1:0]    out_value_q;
	logic                  out_found_q;
	logic                  out_last_q;

	logic [VALUE_BITS-1:0] start_in;
	logic [CNT_W-1:0]      cnt_sat;
	logic                  accept;
	logic                  emit_go;
	logic                  sq_over;
	logic                  mod_start;
	logic [DIV_BITS-1:0]   mod_divisor;
	mod_stat_t             mod_stat;

	pps_mod_unit #(
		.VALUE_BITS(VALUE_BITS),
		.DIV_BITS  (DIV_BITS)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(cand_q),
		.divisor (mod_divisor),
		.stat    (mod_stat)
	);

	always_comb begin
		start_in = req.start_value[VALUE_BITS-1:0];
		cnt_sat  = (req.prime_count > COUNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT)
			: CNT_W'(req.prime_count);
		accept   = req.valid && (state_q == ST_IDLE);
		emit_go  = (state_q == ST_EMIT) && (!res_valid_q || res.ready);
		sq_over  = sq_q > SQ_BITS'(cand_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mod_start   = 1'b0;
		mod_divisor = d_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid && req.prime_count != '0) begin
					if (start_in <= VALUE_BITS'(SMALLEST_PRIME)) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_CAND;
					end
				end
			end
			ST_CAND: begin
				if (cand_q <= VALUE_BITS'(SECOND_PRIME)) begin
					state_d = ST_EMIT;
				end else if (cand_q[0]) begin
					mod_start   = 1'b1;
					mod_divisor = DIV_BITS'(SECOND_PRIME);
					state_d     = ST_MOD3;
				end
			end
			ST_MOD3: begin
				if (mod_stat.done) begin
					state_d = mod_stat.zero ? ST_CAND : ST_CHK;
				end
			end
			ST_CHK: begin
				if (sq_over) begin
					state_d = ST_EMIT;
				end else begin
					mod_start = 1'b1;
					state_d   = ST_MODA;
				end
			end
			ST_MODA: begin
				if (mod_stat.done) begin
					if (mod_stat.zero) begin
						state_d = ST_CAND;
					end else begin
						mod_start   = 1'b1;
						mod_divisor = d_q + DIV_BITS'(PAIR_OFFSET);
						state_d     = ST_MODB;
					end
				end
			end
			ST_MODB: begin
				if (mod_stat.done) begin
					state_d = mod_stat.zero ? ST_CAND : ST_CHK;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = pend_last_q ? ST_IDLE : ST_CAND;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			remaining_q <= '0;
		end else begin
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				remaining_q <= cnt_sat;
			end else if (emit_go) begin
				remaining_q <= pend_last_q ? '0 : remaining_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cand_q       <= start_in - VALUE_BITS'(1);
					pend_found_q <= 1'b0;
					pend_last_q  <= 1'b1;
				end
			end
			ST_CAND: begin
				if (cand_q <= VALUE_BITS'(1)) begin
					pend_found_q <= 1'b0;
					pend_last_q  <= 1'b1;
				end else if (cand_q <= VALUE_BITS'(SECOND_PRIME)) begin
					pend_found_q <= 1'b1;
					pend_last_q  <= (remaining_q == CNT_W'(1));
				end else if (!cand_q[0]) begin
					cand_q <= cand_q - VALUE_BITS'(1);
				end
			end
			ST_MOD3: begin
				if (mod_stat.done) begin
					if (mod_stat.zero) begin
						cand_q <= cand_q - VALUE_BITS'(1);
					end else begin
						d_q  <= DIV_BITS'(FIRST_DIV);
						sq_q <= SQ_BITS'(FIRST_DIV * FIRST_DIV);
					end
				end
			end
			ST_CHK: begin
				if (sq_over) begin
					pend_found_q <= 1'b1;
					pend_last_q  <= (remaining_q == CNT_W'(1));
				end
			end
			ST_MODA: begin
				if (mod_stat.done && mod_stat.zero) begin
					cand_q <= cand_q - VALUE_BITS'(1);
				end
			end
			ST_MODB: begin
				if (mod_stat.done) begin
					if (mod_stat.zero) begin
						cand_q <= cand_q - VALUE_BITS'(1);
					end else begin
						d_q  <= d_q + DIV_BITS'(DIV_STEP);
						sq_q <= sq_q + SQ_BITS'(d_q) * SQ_BITS'(2 * DIV_STEP)
							+ SQ_BITS'(DIV_STEP * DIV_STEP);
					end
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					out_value_q <= pend_found_q ? PRIME_W'(cand_q) : '0;
					out_found_q <= pend_found_q;
					out_last_q  <= pend_last_q;
					cand_q      <= cand_q - VALUE_BITS'(1);
				end
			end
			default: ;
		endcase
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign res.valid       = res_valid_q;
	assign res.prime_value = out_value_q;
	assign res.found       = out_found_q;
	assign res.last        = out_last_q;

`ifndef SYNTHESIS
	a_sq_tracks_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK) |-> (sq_q == SQ_BITS'(d_q) * SQ_BITS'(d_q)))
		else $error("divisor square out of step");

	a_owed_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (remaining_q != '0))
		else $error("search running with nothing owed");

	a_done_in_mod_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_stat.done |-> (state_q == ST_MOD3 || state_q == ST_MODA
			|| state_q == ST_MODB))
		else $error("modulo result outside a modulo wait");

	a_not_found_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !out_found_q) |-> (out_last_q && out_value_q == '0))
		else $error("not-found result malformed");

	a_found_is_prime_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && out_found_q) |-> (out_value_q >= PRIME_W'(SMALLEST_PRIME)))
		else $error("found value below two");
`endif

endmodule

`default_nettype wire

// ===== bench/pps_checker.sv =====
`timescale 1ns / 1ps

module pps_checker
	import pps_pkg::*;
#(
	parameter int MAX_COUNT  = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	pps_req_if   req,
	pps_res_if   res,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic [PRIME_W-1:0] prime_value;
		logic               found;
		logic               last;
	} prime_result_t;

	localparam logic [START_W-1:0] VALUE_MASK = {START_W{1'b1}} >> (START_W - VALUE_BITS);

	prime_result_t primes_due[$];
	int            mismatch_count = 0;
	int            due_count      = 0;

	assign errors  = mismatch_count;
	assign pending = due_count;

	function automatic bit passes_trial_division(logic [PRIME_W-1:0] n);
		logic [PRIME_W-1:0] d;
		logic [63:0]        sq;
		if (n < SMALLEST_PRIME)
			return 1'b0;
		if (n <= SECOND_PRIME)
			return 1'b1;
		if (n % SMALLEST_PRIME == 0 || n % SECOND_PRIME == 0)
			return 1'b0;
		d  = FIRST_DIV;
		sq = {32'd0, d} * {32'd0, d};
		while (sq <= {32'd0, n}) begin
			if (n % d == 0 || n % (d + PAIR_OFFSET) == 0)
				return 1'b0;
			d  = d + DIV_STEP;
			sq = {32'd0, d} * {32'd0, d};
		end
		return 1'b1;
	endfunction

	function automatic logic [PRIME_W-1:0] largest_prime_below(logic [PRIME_W-1:0] n);
		logic [PRIME_W-1:0] c;
		if (n <= SMALLEST_PRIME)
			return '0;
		c = n - 1;
		while (c > 1) begin
			if (passes_trial_division(c))
				return c;
			c = c - 1;
		end
		return '0;
	endfunction

	function automatic void queue_primes(logic [START_W-1:0] start, logic [COUNT_W-1:0] count);
		logic [PRIME_W-1:0] cur;
		logic [PRIME_W-1:0] p;
		int                 owed;
		prime_result_t      item;
		cur  = start & VALUE_MASK;
		owed = (count > MAX_COUNT) ? MAX_COUNT : count;
		while (owed > 0) begin
			p = largest_prime_below(cur);
			if (p == 0) begin
				item = '{prime_value: '0, found: 1'b0, last: 1'b1};
				primes_due.insert(primes_due.size(), item);
				owed = 0;
			end else begin
				owed = owed - 1;
				item = '{prime_value: p, found: 1'b1, last: owed == 0};
				primes_due.insert(primes_due.size(), item);
				cur = p;
			end
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("pps_checker: %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic check_result();
		prime_result_t want;
		if (primes_due.size() == 0) begin
			report_mismatch("result with nothing expected", res.prime_value, 0);
			return;
		end
		want = primes_due.pop_front();
		if (res.prime_value !== want.prime_value)
			report_mismatch("prime_value", res.prime_value, want.prime_value);
		if (res.found !== want.found)
			report_mismatch("found", 32'(res.found), 32'(want.found));
		if (res.last !== want.last)
			report_mismatch("last", 32'(res.last), 32'(want.last));
	endtask

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			check_result();
		if (arst_n && req.valid && req.ready)
			queue_primes(req.start_value, req.prime_count);
		due_count = primes_due.size();
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
	import pps_pkg::*;
;

	localparam int MAX_COUNT      = 64;
	localparam int VALUE_BITS     = 32;
	localparam int RANDOM_ITEMS   = 80;
	localparam int CALM_ITEMS     = 20;
	localparam int LONG_HOLD      = 2000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	bit   calm = 1'b0;
	bit   long_hold_request = 1'b0;
	int   quiet_cycles = 0;

	pps_req_if req_ch();
	pps_res_if res_ch();

	previous_prime_search #(
		.MAX_COUNT(MAX_COUNT),
		.VALUE_BITS(VALUE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	pps_checker #(
		.MAX_COUNT(MAX_COUNT),
		.VALUE_BITS(VALUE_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic offer_request(input logic [START_W-1:0] start, input logic [COUNT_W-1:0] count);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.start_value <= start;
		req_ch.prime_count <= count;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	initial begin : result_sink
		int hold_left;
		int burst_left;
		bit hold_taken;
		hold_left  = 0;
		burst_left = 0;
		hold_taken = 1'b0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (long_hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = LONG_HOLD - 1;
				res_ch.ready <= 1'b0;
			end else if (calm) begin
				res_ch.ready <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
			end else if ($urandom_range(0, 2) == 0) begin
				burst_left = $urandom_range(0, 7);
				res_ch.ready <= 1'b0;
			end else begin
				burst_left = $urandom_range(0, 31);
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : request_source
		logic [START_W-1:0] start;
		logic [COUNT_W-1:0] count;
		int                 served;
		int                 sel;
		req_ch.valid       = 1'b0;
		req_ch.start_value = '0;
		req_ch.prime_count = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		offer_request(32'd0, 7'd1);
		offer_request(32'd1, 7'd1);
		offer_request(32'd2, 7'd1);
		offer_request(32'd3, 7'd1);
		offer_request(32'd4, 7'd1);
		offer_request(32'd5, 7'd2);
		offer_request(32'd10, 7'd5);
		offer_request(32'd100, 7'd0);
		offer_request(32'hFFFF_FFFF, 7'd0);
		offer_request(32'd100, 7'd127);
		offer_request(32'd26, 7'd1);
		offer_request(32'd50, 7'd3);
		offer_request(32'd122, 7'd1);
		long_hold_request = 1'b1;
		offer_request(32'd2000, 7'd64);
		offer_request(32'd2000, 7'd65);
		offer_request(32'd600, 7'd20);
		offer_request(32'd65536, 7'd2);
		offer_request(32'h8000_0000, 7'd1);
		offer_request(32'd7, 7'd1);

		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);

		served = 0;
		while (served < RANDOM_ITEMS) begin
			calm = (served >= RANDOM_ITEMS - CALM_ITEMS);
			sel  = $urandom_range(0, 99);
			if (sel < 5) begin
				start = $urandom_range(0, (1 << 20) - 1);
				count = COUNT_W'($urandom_range(1, 2));
			end else if (sel < 25) begin
				start = $urandom_range(0, 65535);
				count = COUNT_W'($urandom_range(1, 2));
			end else if (sel < 30) begin
				start = $urandom;
				count = '0;
			end else if (sel < 40) begin
				start = $urandom_range(0, 600);
				count = COUNT_W'($urandom_range(MAX_COUNT, 127));
			end else begin
				start = $urandom_range(0, 4095);
				count = COUNT_W'($urandom_range(1, 8));
			end
			offer_request(start, count);
			if (count != 0)
				served++;
		end

		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ===== previous_prime_search.f =====
design/pps_pkg.sv
design/pps_req_if.sv
design/pps_res_if.sv
design/pps_mod_unit.sv
design/previous_prime_search.sv
bench/pps_checker.sv
bench/tb_top.sv
